>>> hdl/ultrasonic_ranging_round_robin_unit_macros.svh
// assertion macros shared by the checker of the ranging unit
`ifndef ULTRASONIC_RANGING_ROUND_ROBIN_UNIT_MACROS_SVH
`define ULTRASONIC_RANGING_ROUND_ROBIN_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define URR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define URR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/urr_pkg.sv
// shared types, constants and calibration table of the ranging unit
package urr_pkg;

	// fixed block constants
	localparam int SENSOR_COUNT = 6;
	localparam int ECHO_US_PER_CM = 57;
	localparam int URR_QUEUE_DEPTH = 4;

	// reciprocal for the echo time divide, floor(2^31 / us per cm)
	localparam logic [31:0] ECHO_RECIP = 32'((64'd1 << 31) / ECHO_US_PER_CM);

	// register reset values
	localparam logic [9:0] PING_INTERVAL_RST = 10'd33;
	localparam logic [8:0] MAX_DISTANCE_RST = 9'd200;
	localparam logic [8:0] MIN_DISTANCE_RST = 9'd2;

	// register indexes
	localparam logic [1:0] REG_PING = 2'd0;
	localparam logic [1:0] REG_MAX = 2'd1;
	localparam logic [1:0] REG_MIN = 2'd2;

	// command and result kind codes
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ECHO = 1'b1;
	localparam logic KIND_TRIGGER = 1'b0;
	localparam logic KIND_RANGE = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] echo_us;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  sensor;
		logic [16:0] distance_q8_cm;
		logic        no_echo;
	} rsp_t;

	typedef struct packed {
		logic [9:0] ping_interval_ms;
		logic [8:0] max_distance_cm;
		logic [8:0] min_distance_cm;
	} cfg_t;

	// work item handed from the front to the back
	typedef struct packed {
		logic        kind;
		logic [3:0]  sensor;
		logic [15:0] echo_us;
	} job_t;

	// cubic calibration coefficients, Q40
	typedef struct packed {
		logic signed [22:0] c0;
		logic signed [31:0] c1;
		logic signed [41:0] c2;
		logic signed [43:0] c3;
	} coef_t;

	// per-sensor calibration, identity beyond the sixth sensor
	function automatic coef_t coef_lookup(input logic [3:0] sensor);
		coef_t c;
		case (sensor)
			4'd0: c = '{23'sd2199023, -32'sd1319413953, 42'sd1297423720776,
				-44'sd5531093243527};
			4'd1: c = '{23'sd769658, -32'sd219902326, 42'sd1129088490563,
				-44'sd91699269757};
			4'd2: c = '{-23'sd4398, -32'sd87960930, 42'sd1138544290562,
				-44'sd1872358350940};
			4'd3: c = '{23'sd2199023, -32'sd879609302, 42'sd1213421032414,
				-44'sd2307874906702};
			4'd4: c = '{23'sd2199023, -32'sd989560465, 42'sd1211771764972,
				-44'sd2471372285752};
			4'd5: c = '{23'sd1099512, -32'sd439804651, 42'sd1151298625444,
				-44'sd1195938797532};
			default: c = '{23'sd0, 32'sd0, 42'sd1099511627776, 44'sd0};
		endcase
		return c;
	endfunction

endpackage

>>> hdl/ultrasonic_ranging_round_robin_unit.sv
// top level of the round-robin ultrasonic ranging unit
// Usage:
//   req channel (req_valid, req_stall, req): one millisecond tick (cmd = tick)
//   or an echo time for the current sensor (cmd = echo, echo_us = 0 for none).
//   rsp channel (rsp_valid, rsp_stall, rsp): trigger requests and range reports
//   in Q8 cm, in the order of the items that caused them.
//   cfg_we / cfg_index / cfg_data write ping interval, max and min distance;
//   write them only while the unit is idle.
// Path: a trigger passes the job queue and the back end's result register, a
//   range report also the sequencer states before that register; a no-echo
//   report is as fast as a trigger.
// Throughput: ticks are taken every cycle while the job queue has room; the
//   back end corrects one echo at a time, stepping through the divide, multiply
//   and clamp states of its sequencer; the two Horner products share one multiplier.
// Reset clears the tick count, selects sensor 0, empties the queue and loads
//   the register defaults (33 ms, 200 cm, 2 cm).
// A stalled rsp holds its item; the queue then fills and req_stall rises.
module ultrasonic_ranging_round_robin_unit import urr_pkg::*; #(
	parameter int QUEUE_DEPTH = URR_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	cfg_t cfg_q;
	logic job_in_valid;
	logic job_in_stall;
	job_t job_in;
	logic job_out_valid;
	logic job_out_stall;
	job_t job_out;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{PING_INTERVAL_RST, MAX_DISTANCE_RST, MIN_DISTANCE_RST};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PING: cfg_q.ping_interval_ms <= cfg_data;
				REG_MAX:  cfg_q.max_distance_cm <= cfg_data[8:0];
				REG_MIN:  cfg_q.min_distance_cm <= cfg_data[8:0];
				default:  cfg_q <= cfg_q;
			endcase
		end
	end

	urr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.job_valid (job_in_valid),
		.job_stall (job_in_stall),
		.job       (job_in)
	);

	urr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (job_in_valid),
		.in_stall  (job_in_stall),
		.in_job    (job_in),
		.out_valid (job_out_valid),
		.out_stall (job_out_stall),
		.out_job   (job_out)
	);

	urr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_out_valid),
		.job_stall (job_out_stall),
		.job       (job_out),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

>>> hdl/urr_front.sv
// front part: tick counting, trigger decision and sensor rotation
module urr_front import urr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic job_valid,
	input  logic job_stall,
	output job_t job
);

	logic [9:0] ms_q;
	logic [3:0] sensor_q;
	logic [9:0] ms_next;
	logic       fire;
	logic       accept;

	// saturating tick count and interval compare
	always_comb begin
		ms_next = (ms_q < 10'd1023) ? ms_q + 10'd1 : 10'd1023;
		fire = ms_next >= cfg.ping_interval_ms;
		accept = req_valid && !job_stall;
	end

	// only ticks that fire and all echoes produce work
	assign req_stall = job_stall;
	assign job_valid = req_valid && ((req.cmd == CMD_ECHO) || fire);
	assign job.kind = (req.cmd == CMD_ECHO) ? KIND_RANGE : KIND_TRIGGER;
	assign job.sensor = sensor_q;
	assign job.echo_us = req.echo_us;

	// tick counter and current sensor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q <= '0;
			sensor_q <= '0;
		end else if (accept) begin
			if (req.cmd == CMD_TICK) begin
				ms_q <= fire ? '0 : ms_next;
			end else begin
				sensor_q <= (sensor_q >= 4'(SENSOR_COUNT - 1)) ? '0 : sensor_q + 4'd1;
			end
		end
	end

endmodule

>>> hdl/urr_queue.sv
// short job queue between the front and the back
module urr_queue import urr_pkg::*; #(
	parameter int DEPTH = URR_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  job_t in_job,
	output logic out_valid,
	input  logic out_stall,
	output job_t out_job
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_stall = (count_q == CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_job = mem_q[rd_ptr_q];
	assign push = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_job;
		end
	end

endmodule

>>> hdl/urr_back.sv
// back part: echo divide, cubic correction, clamp and result register
module urr_back import urr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic job_valid,
	output logic job_stall,
	input  job_t job,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_RECIP, S_FIX, S_CORR, S_P1, S_A1, S_P2, S_A2,
		S_ABS, S_P3, S_A3, S_A4, S_DONE
	} state_t;

	state_t             state_q;
	logic [3:0]         sensor_q;
	coef_t              coef_q;
	logic [23:0]        n_q;
	logic [55:0]        prod_q;
	logic [18:0]        q0_q;
	logic [23:0]        qd_q;
	logic [18:0]        x_q;
	logic signed [53:0] p_q;
	logic signed [33:0] t1_q;
	logic signed [45:0] qv_q;
	logic [44:0]        m_q;
	logic               neg_q;
	logic [39:0]        hx_q;
	logic [42:0]        lo_q;
	logic               huge_q;
	logic [50:0]        p40_q;
	logic signed [52:0] r_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               out_free;
	logic               rsp_load;
	logic [55:0]        prod_d;
	logic [18:0]        q0_d;
	logic [23:0]        qd_d;
	logic [23:0]        rem_d;
	logic [18:0]        x_d;
	logic signed [19:0] x_s;
	logic signed [33:0] mul_a;
	logic signed [53:0] mul_p;
	logic [53:0]        p_bias;
	logic signed [45:0] tr;
	logic signed [33:0] t1_d;
	logic signed [45:0] qv_d;
	logic [44:0]        m_d;
	logic [39:0]        hx_d;
	logic [42:0]        lo_d;
	logic [58:0]        pm_d;
	logic signed [52:0] r_d;
	logic [20:0]        v_d;
	logic [16:0]        lim_lo;
	logic [16:0]        lim_hi;
	logic [16:0]        dist_d;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign job_stall = !((state_q == S_IDLE) && out_free);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// a result is loaded for triggers, no-echo reports and finished corrections
	always_comb begin
		rsp_load = out_free && ((state_q == S_DONE) || ((state_q == S_IDLE) && job_valid &&
			((job.kind == KIND_TRIGGER) || (job.echo_us == 16'd0))));
	end

	// echo divide by reciprocal with one correction step
	always_comb begin
		prod_d = 56'(n_q) * 56'(ECHO_RECIP);
		q0_d = prod_q[49:31];
		qd_d = 24'(q0_d) * 24'(ECHO_US_PER_CM);
		rem_d = n_q - qd_q;
		x_d = (rem_d >= 24'(ECHO_US_PER_CM)) ? q0_q + 19'd1 : q0_q;
	end

	// shared signed multiplier for the two horner products
	always_comb begin
		x_s = $signed({1'b0, x_q});
		mul_a = (state_q == S_P1) ? 34'($signed(coef_q.c0)) : t1_q;
		mul_p = mul_a * x_s;
	end

	// divide by 256 toward zero, then add the next coefficient
	always_comb begin
		p_bias = p_q + {46'd0, {8{p_q[53]}}};
		tr = p_bias[53:8];
		t1_d = 34'(tr + 46'($signed(coef_q.c1)));
		qv_d = tr + 46'($signed(coef_q.c2));
		m_d = qv_q[45] ? 45'(-qv_q) : 45'(qv_q);
	end

	// last product split into high and low halves of the magnitude
	always_comb begin
		hx_d = 40'(m_q[44:24]) * 40'(x_q);
		lo_d = 43'(m_q[23:0]) * 43'(x_q);
		pm_d = {1'b0, hx_q[33:0], 24'd0} + 59'(lo_q);
		if (neg_q) begin
			r_d = 53'($signed(coef_q.c3)) - $signed({2'b00, p40_q});
		end else begin
			r_d = 53'($signed(coef_q.c3)) + $signed({2'b00, p40_q});
		end
	end

	// clamp to the configured range, below-min checked first
	always_comb begin
		lim_lo = {cfg.min_distance_cm, 8'd0};
		lim_hi = {cfg.max_distance_cm, 8'd0};
		v_d = r_q[52:32];
		if (huge_q) begin
			dist_d = neg_q ? lim_lo : lim_hi;
		end else if (r_q[52]) begin
			dist_d = lim_lo;
		end else if (v_d < 21'(lim_lo)) begin
			dist_d = lim_lo;
		end else if (v_d > 21'(lim_hi)) begin
			dist_d = lim_hi;
		end else begin
			dist_d = v_d[16:0];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
			sensor_q <= '0;
			coef_q <= '0;
			n_q <= '0;
			prod_q <= '0;
			q0_q <= '0;
			qd_q <= '0;
			x_q <= '0;
			p_q <= '0;
			t1_q <= '0;
			qv_q <= '0;
			m_q <= '0;
			neg_q <= 1'b0;
			hx_q <= '0;
			lo_q <= '0;
			huge_q <= 1'b0;
			p40_q <= '0;
			r_q <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_valid && out_free) begin
						if (job.kind == KIND_TRIGGER) begin
							rsp_q <= '{KIND_TRIGGER, job.sensor, 17'd0, 1'b0};
						end else if (job.echo_us == 16'd0) begin
							rsp_q <= '{KIND_RANGE, job.sensor,
								{cfg.max_distance_cm, 8'd0}, 1'b1};
						end else begin
							sensor_q <= job.sensor;
							coef_q <= coef_lookup(job.sensor);
							n_q <= {job.echo_us, 8'd0};
							state_q <= S_RECIP;
						end
					end
				end
				S_RECIP: begin
					prod_q <= prod_d;
					state_q <= S_FIX;
				end
				S_FIX: begin
					q0_q <= q0_d;
					qd_q <= qd_d;
					state_q <= S_CORR;
				end
				S_CORR: begin
					x_q <= x_d;
					state_q <= S_P1;
				end
				S_P1: begin
					p_q <= mul_p;
					state_q <= S_A1;
				end
				S_A1: begin
					t1_q <= t1_d;
					state_q <= S_P2;
				end
				S_P2: begin
					p_q <= mul_p;
					state_q <= S_A2;
				end
				S_A2: begin
					qv_q <= qv_d;
					state_q <= S_ABS;
				end
				S_ABS: begin
					m_q <= m_d;
					neg_q <= qv_q[45];
					state_q <= S_P3;
				end
				S_P3: begin
					hx_q <= hx_d;
					lo_q <= lo_d;
					state_q <= S_A3;
				end
				S_A3: begin
					huge_q <= |hx_q[39:34];
					p40_q <= pm_d[58:8];
					state_q <= S_A4;
				end
				S_A4: begin
					r_q <= r_d;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						rsp_q <= '{KIND_RANGE, sensor_q, dist_d, 1'b0};
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/urr_checker.sv
// port-level checker of the ranging unit and its bind
`include "ultrasonic_ranging_round_robin_unit_macros.svh"

module urr_checker import urr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a stalled result stays offered and unchanged
	`URR_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled rsp changed")

	// trigger requests carry no distance and no no-echo flag
	`URR_ASSERT_IMP(a_trig_clean, rsp_valid && rsp.kind == KIND_TRIGGER, rsp.distance_q8_cm == 17'd0 && !rsp.no_echo, "trigger with payload")

	// sensor index stays within the sensor count
	`URR_ASSERT_IMP(a_sensor_range, rsp_valid, rsp.sensor < 4'(SENSOR_COUNT), "sensor out of range")

	// no-echo flag only on range reports
	`URR_ASSERT_IMP(a_no_echo_kind, rsp_valid && rsp.no_echo, rsp.kind == KIND_RANGE, "no-echo on trigger")

endmodule

bind ultrasonic_ranging_round_robin_unit urr_checker u_urr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

>>> sim/ultrasonic_ranging_round_robin_unit_tb.sv
// self-checking testbench of the round-robin ultrasonic ranging unit
module ultrasonic_ranging_round_robin_unit_tb;
	import urr_pkg::*;

	// index with no register behind it, writes to it are dropped
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 20;
	localparam int BACKLOG_CYCLES = 400;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 160;
	localparam int DIR_ROWS = 28;

	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  idx;
		logic [9:0]  data;
		req_t        item;
		logic        typed;
		rsp_t        want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_data;

	// ranging state mirrored on the test side
	logic [9:0]  ping_ms;
	logic [8:0]  max_cm;
	logic [8:0]  min_cm;
	logic [9:0]  ms_count;
	logic [3:0]  cur_sensor;

	rsp_t        ranging_due[$];
	rsp_t        want_rsp;
	plan_row_t   dir_plan [DIR_ROWS];
	int          gap_pct = 20;
	int          hold_left = 0;
	bit          backlog_ask = 1'b0;
	int          fails = 0;
	int          n_sent = 0;
	int          n_trig = 0;
	int          n_rep = 0;
	int          n_noecho = 0;
	int          n_settings = 0;
	int          cycle_count = 0;

	ultrasonic_ranging_round_robin_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// calibrated distance of one echo, Q8 cm after clamping
	function automatic logic [16:0] corrected_q8(input logic [3:0] sel, input logic [15:0] echo);
		longint cub, quad, lin, ofs, x, t1, q, r;
		logic [63:0] mag, hx, pm, p40, v;
		logic [16:0] lo, hi;
		begin
			case (sel)
				4'd0: begin
					cub = 64'sd2199023; quad = -64'sd1319413953;
					lin = 64'sd1297423720776; ofs = -64'sd5531093243527;
				end
				4'd1: begin
					cub = 64'sd769658; quad = -64'sd219902326;
					lin = 64'sd1129088490563; ofs = -64'sd91699269757;
				end
				4'd2: begin
					cub = -64'sd4398; quad = -64'sd87960930;
					lin = 64'sd1138544290562; ofs = -64'sd1872358350940;
				end
				4'd3: begin
					cub = 64'sd2199023; quad = -64'sd879609302;
					lin = 64'sd1213421032414; ofs = -64'sd2307874906702;
				end
				4'd4: begin
					cub = 64'sd2199023; quad = -64'sd989560465;
					lin = 64'sd1211771764972; ofs = -64'sd2471372285752;
				end
				4'd5: begin
					cub = 64'sd1099512; quad = -64'sd439804651;
					lin = 64'sd1151298625444; ofs = -64'sd1195938797532;
				end
				default: begin
					cub = 64'sd0; quad = 64'sd0; lin = 64'sd1099511627776; ofs = 64'sd0;
				end
			endcase
			lo = {min_cm, 8'd0};
			hi = {max_cm, 8'd0};
			x = longint'(({48'd0, echo} << 8) / 64'(ECHO_US_PER_CM));
			// horner steps, each rescale truncates toward zero
			t1 = cub * x / 256 + quad;
			q = t1 * x / 256 + lin;
			mag = (q < 0) ? -q : q;
			hx = (mag >> 24) * x;
			// product of 1024 cm or more: sign alone decides
			if (hx >= (64'd1 << 34))
				return (q >= 0) ? hi : lo;
			pm = (hx << 24) + (mag & 64'hFF_FFFF) * x;
			p40 = pm >> 8;
			r = (q < 0) ? -longint'(p40) : longint'(p40);
			r = r + ofs;
			if (r < 0)
				return lo;
			v = r >> 32;
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v[16:0];
		end
	endfunction

	// advance the mirrored state by one transfer
	task automatic ranging_step(input req_t r, output logic hit, output rsp_t res);
		logic [9:0] nxt;
		begin
			res = '0;
			hit = 1'b1;
			if (r.cmd == CMD_TICK) begin
				nxt = (ms_count < 10'd1023) ? ms_count + 10'd1 : 10'd1023;
				if (nxt >= ping_ms) begin
					ms_count = '0;
					res.kind = KIND_TRIGGER;
					res.sensor = cur_sensor;
				end else begin
					ms_count = nxt;
					hit = 1'b0;
				end
			end else begin
				res.kind = KIND_RANGE;
				res.sensor = cur_sensor;
				if (r.echo_us == 16'd0) begin
					res.distance_q8_cm = {max_cm, 8'd0};
					res.no_echo = 1'b1;
				end else begin
					res.distance_q8_cm = corrected_q8(cur_sensor, r.echo_us);
				end
				cur_sensor = (int'(cur_sensor) + 1 >= SENSOR_COUNT) ? 4'd0 : cur_sensor + 4'd1;
			end
		end
	endtask

	// offer one item until it transfers, then log what it should cause
	task automatic send_req(input req_t r, input logic typed, input rsp_t want);
		logic hit;
		rsp_t res;
		begin
			while ($urandom_range(99) < gap_pct) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
			req_valid <= 1'b1;
			req <= r;
			@(posedge clk);
			while (req_stall)
				@(posedge clk);
			ranging_step(r, hit, res);
			if (typed)
				ranging_due.push_back(want);
			else if (hit)
				ranging_due.push_back(res);
			n_sent++;
		end
	endtask

	// drain everything in flight before touching a register
	task automatic settle();
		begin
			req_valid <= 1'b0;
			while (ranging_due.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
		begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
			cfg_we <= 1'b0;
			@(posedge clk);
			case (idx)
				REG_PING: ping_ms = data;
				REG_MAX:  max_cm = data[8:0];
				REG_MIN:  min_cm = data[8:0];
				default: ;
			endcase
		end
	endtask

	function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [9:0] data);
		plan_row_t row;
		begin
			row = '0;
			row.is_cfg = 1'b1;
			row.idx = idx;
			row.data = data;
			return row;
		end
	endfunction

	function automatic plan_row_t item_row(input logic cmd, input logic [15:0] echo);
		plan_row_t row;
		begin
			row = '0;
			row.item.cmd = cmd;
			row.item.echo_us = echo;
			return row;
		end
	endfunction

	function automatic plan_row_t known_row(input logic cmd, input logic [15:0] echo,
			input logic kind, input logic [3:0] sensor, input logic [16:0] dist_q8,
			input logic noecho);
		plan_row_t row;
		begin
			row = item_row(cmd, echo);
			row.typed = 1'b1;
			row.want.kind = kind;
			row.want.sensor = sensor;
			row.want.distance_q8_cm = dist_q8;
			row.want.no_echo = noecho;
			return row;
		end
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (backlog_ask) begin
				backlog_ask = 1'b0;
				hold_left = BACKLOG_CYCLES;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < gap_pct);
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (ranging_due.size() == 0) begin
				$display("%0t: unexpected result kind %0d sensor %0d dist %0d no_echo %0d",
					$time, rsp.kind, rsp.sensor, rsp.distance_q8_cm, rsp.no_echo);
				fails++;
			end else begin
				want_rsp = ranging_due.pop_front();
				if (rsp.kind !== want_rsp.kind) begin
					$display("%0t: kind expected %0d got %0d", $time, want_rsp.kind, rsp.kind);
					fails++;
				end
				if (rsp.sensor !== want_rsp.sensor) begin
					$display("%0t: sensor expected %0d got %0d", $time, want_rsp.sensor,
						rsp.sensor);
					fails++;
				end
				if (rsp.distance_q8_cm !== want_rsp.distance_q8_cm) begin
					$display("%0t: distance expected %0d got %0d", $time,
						want_rsp.distance_q8_cm, rsp.distance_q8_cm);
					fails++;
				end
				if (rsp.no_echo !== want_rsp.no_echo) begin
					$display("%0t: no_echo expected %0d got %0d", $time, want_rsp.no_echo,
						rsp.no_echo);
					fails++;
				end
			end
			if (rsp.kind == KIND_TRIGGER)
				n_trig++;
			else
				n_rep++;
			if (rsp.no_echo === 1'b1)
				n_noecho++;
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		req_t item;
		logic [9:0] p_ping, p_max, p_min;
		int pick;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_PING;
		cfg_data <= '0;
		ping_ms = PING_INTERVAL_RST;
		max_cm = MAX_DISTANCE_RST;
		min_cm = MIN_DISTANCE_RST;
		ms_count = '0;
		cur_sensor = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults, wrap of the sensor index, interval zero,
		// min above max, widest range, echo without a trigger
		dir_plan = '{
			known_row(CMD_ECHO, 16'd0, KIND_RANGE, 4'd0, 17'd51200, 1'b1),
			item_row(CMD_ECHO, 16'hFFFF),
			item_row(CMD_ECHO, 16'd1),
			item_row(CMD_ECHO, 16'd114),
			item_row(CMD_ECHO, 16'h5555),
			item_row(CMD_ECHO, 16'hAAAA),
			item_row(CMD_ECHO, 16'd3000),
			item_row(CMD_TICK, 16'hFFFF),
			cfg_row(REG_PING, 10'd0),
			known_row(CMD_TICK, 16'd0, KIND_TRIGGER, 4'd1, 17'd0, 1'b0),
			known_row(CMD_TICK, 16'd0, KIND_TRIGGER, 4'd1, 17'd0, 1'b0),
			cfg_row(REG_PING, 10'd2),
			item_row(CMD_TICK, 16'd0),
			known_row(CMD_TICK, 16'd0, KIND_TRIGGER, 4'd1, 17'd0, 1'b0),
			cfg_row(REG_MAX, 10'd0),
			cfg_row(REG_MIN, 10'd511),
			known_row(CMD_ECHO, 16'd0, KIND_RANGE, 4'd1, 17'd0, 1'b1),
			item_row(CMD_ECHO, 16'd500),
			cfg_row(REG_MAX, 10'd511),
			cfg_row(REG_MIN, 10'd0),
			cfg_row(REG_NONE, 10'h3FF),
			known_row(CMD_ECHO, 16'd0, KIND_RANGE, 4'd3, 17'd130816, 1'b1),
			item_row(CMD_ECHO, 16'hFFFF),
			item_row(CMD_ECHO, 16'h8000),
			item_row(CMD_ECHO, 16'h7FFF),
			cfg_row(REG_PING, 10'd1023),
			item_row(CMD_TICK, 16'd0),
			item_row(CMD_ECHO, 16'd57)
		};
		foreach (dir_plan[i]) begin
			if (dir_plan[i].is_cfg) begin
				settle();
				write_reg(dir_plan[i].idx, dir_plan[i].data);
				n_settings++;
			end else begin
				send_req(dir_plan[i].item, dir_plan[i].typed, dir_plan[i].want);
			end
		end

		// random phases, each under its own register setting
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin p_ping = 10'd33; p_max = 10'd200; p_min = 10'd2; end
				1: begin p_ping = 10'd1; p_max = 10'd500; p_min = 10'd0; end
				2: begin p_ping = 10'd0; p_max = 10'd511; p_min = 10'd511; end
				3: begin
					p_ping = 10'($urandom_range(1, 40));
					p_max = 10'($urandom_range(1, 500));
					p_min = 10'($urandom_range(0, p_max));
				end
				4: begin
					p_ping = 10'($urandom_range(0, 10));
					p_max = 10'($urandom_range(1, 100));
					p_min = 10'($urandom_range(200, 511));
				end
				5: begin p_ping = 10'd1023; p_max = 10'd1; p_min = 10'd0; end
				default: begin
					// upper data bit is beyond the distance registers
					p_ping = 10'($urandom_range(1, 60));
					p_max = 10'($urandom_range(0, 1023));
					p_min = 10'($urandom_range(0, 1023));
				end
			endcase
			settle();
			write_reg(REG_PING, p_ping);
			write_reg(REG_MAX, p_max);
			write_reg(REG_MIN, p_min);
			n_settings++;
			// one phase runs with no idling on either side
			gap_pct = (ph == 1) ? 0 : 20;
			if (ph == 3)
				backlog_ask = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				item.cmd = ($urandom_range(1) == 1) ? CMD_ECHO : CMD_TICK;
				pick = $urandom_range(99);
				if (item.cmd == CMD_TICK)
					item.echo_us = 16'($urandom());
				else if (pick < 10)
					item.echo_us = 16'd0;
				else if (pick < 70)
					item.echo_us = 16'($urandom_range(1, 30000));
				else if (pick < 85)
					item.echo_us = 16'($urandom_range(30000, 65535));
				else
					item.echo_us = 16'($urandom());
				send_req(item, 1'b0, '0);
			end
		end

		settle();
		repeat (30) @(posedge clk);
		$display("%0d items under %0d register settings, backlog hold of %0d cycles",
			n_sent, n_settings, BACKLOG_CYCLES);
		$display("%0d trigger requests and %0d range reports, %0d without echo",
			n_trig, n_rep, n_noecho);
		if (fails == 0 && ranging_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
